[hw/rtl/fft_frame_equalizer_core_assert.svh]
// Assertion macros for the equalizer RTL.
`ifndef FFT_FRAME_EQUALIZER_CORE_ASSERT_SVH
`define FFT_FRAME_EQUALIZER_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define FFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("equalizer assertion failed");
// Next-cycle implication, checked out of reset.
`define FFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("equalizer assertion failed");
`else
`define FFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/ffe_pkg.sv]
// Types, constants and twiddle tables of the frame equalizer.
`timescale 1ns / 1ps
package ffe_pkg;

  localparam int FRAME_SIZE  = 1024;
  localparam int LOG_N       = 10;
  localparam int SAMPLE_BITS = 16;
  localparam int GAIN_BITS   = 12;
  localparam int GAIN_FRAC   = GAIN_BITS - 4;
  localparam int GUARD       = 24 - SAMPLE_BITS;
  localparam int WORD_W      = 40;
  localparam int TW_W        = 17;
  localparam int QUARTER     = FRAME_SIZE / 4;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef logic [LOG_N-1:0]              addr_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [GAIN_BITS-1:0]          gain_t;
  typedef logic signed [TW_W-1:0]        tw_t;
  typedef logic signed [WORD_W-1:0]      word_t;

  typedef struct packed {
    word_t re;
    word_t im;
  } cplx_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    gain_t val;
  } gain_wr_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    word_t re;
  } pb_wr_t;

  typedef struct packed {
    logic tw_ld;
    logic mul_ld;
    logic sum_ld;
    logic inverse;
  } bf_ctl_t;

  typedef struct packed {
    tw_t c;
    tw_t s;
  } twiddle_t;

  typedef logic [TW_W-1:0] qsin_tab_t [0:QUARTER-1];

  // Q30 Taylor series of sine with truncated terms, rounded half up to Q15.
  function automatic logic [TW_W-1:0] sin_q15(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd272; sum = sum + signed'(term);
    if (sum < 0) begin
      sum = 0;
    end
    return TW_W'((sum + 64'sd16384) >>> 15);
  endfunction

  function automatic qsin_tab_t build_qsin();
    qsin_tab_t t;
    for (int k = 0; k < QUARTER; k++) begin
      t[k] = sin_q15((PI_Q30 * 64'd2 * 64'(k)) / FRAME_SIZE);
    end
    return t;
  endfunction

  localparam qsin_tab_t QSIN_TAB = build_qsin();
  localparam logic [TW_W-1:0] QSIN_TOP =
    sin_q15((PI_Q30 * 64'd2 * 64'(QUARTER)) / FRAME_SIZE);

  // Quarter-wave lookup, index 0 .. QUARTER.
  function automatic tw_t qsin(input logic [LOG_N-2:0] idx);
    if (idx == (LOG_N-1)'(QUARTER)) begin
      return signed'(QSIN_TOP);
    end
    return signed'(QSIN_TAB[idx[LOG_N-3:0]]);
  endfunction

  // Cosine and sine of 2*pi*k/FRAME_SIZE for k below FRAME_SIZE/2.
  function automatic twiddle_t twiddle(input logic [LOG_N-2:0] k);
    twiddle_t w;
    logic [LOG_N-1:0] kk;
    kk = {1'b0, k};
    if (kk <= LOG_N'(QUARTER)) begin
      w.c = qsin((LOG_N-1)'(LOG_N'(QUARTER) - kk));
      w.s = qsin(k);
    end else begin
      w.c = -qsin((LOG_N-1)'(kk - LOG_N'(QUARTER)));
      w.s = qsin((LOG_N-1)'(LOG_N'(2 * QUARTER) - kk));
    end
    return w;
  endfunction

  function automatic addr_t bitrev(input addr_t a);
    addr_t r;
    for (int b = 0; b < LOG_N; b++) begin
      r[b] = a[LOG_N-1-b];
    end
    return r;
  endfunction

endpackage

[hw/rtl/fft_frame_equalizer_core.sv]
// Frame equalizer top: capture, FFT sequencer, work memory, gain and playback.
// Each sample transaction gets its result in the next cycle; the result carries the
//   same position of the previous frame; the receiver cannot stall.
// Throughput: one transaction per cycle inside a frame, then busy through the forward
//   FFT, the gain pass, the inverse FFT and the output pass.
// Reset: synchronous, active low; a gain clearing sweep over every entry follows.
`timescale 1ns / 1ps
`include "fft_frame_equalizer_core_assert.svh"
module fft_frame_equalizer_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_mode,
  input  ffe_pkg::sample_t in_sample_in,
  input  ffe_pkg::addr_t   in_gain_index,
  input  ffe_pkg::gain_t   in_gain_value,
  output logic             out_valid,
  output ffe_pkg::sample_t out_sample_out,
  output logic             out_frame_last
);
  import ffe_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_BF_RD  = 12'b000000000010,
    S_BF_MUL = 12'b000000000100,
    S_BF_SUM = 12'b000000001000,
    S_BF_WA  = 12'b000000010000,
    S_BF_WB  = 12'b000000100000,
    S_GN_RD  = 12'b000001000000,
    S_GN_MUL = 12'b000010000000,
    S_GN_WA  = 12'b000100000000,
    S_GN_WB  = 12'b001000000000,
    S_OUT_RD = 12'b010000000000,
    S_OUT_LAST = 12'b100000000000
  } state_t;

  localparam int ST_W = 4;
  localparam int P_W  = WORD_W + GAIN_BITS + 1;

  state_t state_r, state_nxt;
  addr_t  pos_r, pos_nxt;
  logic [ST_W-1:0]  stage_r, stage_nxt;
  logic [LOG_N-2:0] bf_r, bf_nxt;
  addr_t  idx_r, idx_nxt;
  logic   inv_r, inv_nxt;
  logic   played_r, played_nxt;
  logic   out_valid_r, out_last_r, out_zero_r;
  logic   rd_pend_r;
  addr_t  rd_addr_r;
  cplx_t  sc_i_r, sc_j_r;

  logic   accept, acc_smp, clearing;
  addr_t  mask, a_addr, b_addr, rv;
  logic [LOG_N-2:0] tw_k;
  twiddle_t w;

  // Work memory ports.
  cplx_t  work_mem [0:FRAME_SIZE-1];
  logic   we, re_a, re_b;
  addr_t  wa, ra, rb;
  cplx_t  wd, wq_a, wq_b;

  bf_ctl_t  bf_ctl;
  cplx_t    a_new, b_new;
  gain_wr_t gain_wr;
  gain_t    gq_a, gq_b;
  logic     g_rd;
  pb_wr_t   pb_wr;
  sample_t  pb_q;

  assign accept  = start && !busy;
  assign acc_smp = accept && !in_mode;
  assign busy    = (state_r != S_IDLE) || clearing;

  // Butterfly addressing for the current stage.
  assign mask   = (addr_t'(1) << stage_r) - addr_t'(1);
  assign a_addr = (((addr_t'(bf_r)) >> stage_r) << (stage_r + ST_W'(1)))
                  | (addr_t'(bf_r) & mask);
  assign b_addr = a_addr | (addr_t'(1) << stage_r);
  assign tw_k   = (LOG_N-1)'((addr_t'(bf_r) & mask) << (ST_W'(LOG_N - 1) - stage_r));
  assign w      = twiddle(tw_k);
  assign rv     = bitrev(idx_r);

  function automatic word_t scale(input word_t v, input gain_t g);
    logic signed [P_W-1:0] p;
    p = v * signed'({1'b0, g});
    return WORD_W'((p + P_W'(1 << (GAIN_FRAC - 1))) >>> GAIN_FRAC);
  endfunction

  // Work memory port selection.
  always_comb begin
    we   = 1'b0;
    wa   = '0;
    wd   = '0;
    re_a = 1'b0;
    re_b = 1'b0;
    ra   = '0;
    rb   = '0;
    g_rd = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        we    = acc_smp;
        wa    = bitrev(pos_r);
        wd.re = WORD_W'(in_sample_in) <<< GUARD;
        wd.im = '0;
      end
      S_BF_RD: begin
        re_a = 1'b1;
        re_b = 1'b1;
        ra   = a_addr;
        rb   = b_addr;
      end
      S_BF_WA: begin
        we = 1'b1;
        wa = a_addr;
        wd = a_new;
      end
      S_BF_WB: begin
        we = 1'b1;
        wa = b_addr;
        wd = b_new;
      end
      S_GN_RD: begin
        re_a = !(rv < idx_r);
        re_b = !(rv < idx_r);
        g_rd = !(rv < idx_r);
        ra   = idx_r;
        rb   = rv;
      end
      S_GN_WA: begin
        we = 1'b1;
        wa = rv;
        wd = sc_i_r;
      end
      S_GN_WB: begin
        we = 1'b1;
        wa = idx_r;
        wd = sc_j_r;
      end
      S_OUT_RD: begin
        re_a = 1'b1;
        ra   = idx_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      work_mem[wa] <= wd;
    end
    if (re_a) begin
      wq_a <= work_mem[ra];
    end
    if (re_b) begin
      wq_b <= work_mem[rb];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    stage_nxt  = stage_r;
    bf_nxt     = bf_r;
    idx_nxt    = idx_r;
    inv_nxt    = inv_r;
    played_nxt = played_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc_smp) begin
          pos_nxt = pos_r + addr_t'(1);
          if (pos_r == addr_t'(FRAME_SIZE - 1)) begin
            state_nxt = S_BF_RD;
            stage_nxt = '0;
            bf_nxt    = '0;
            inv_nxt   = 1'b0;
          end
        end
      end
      S_BF_RD:  state_nxt = S_BF_MUL;
      S_BF_MUL: state_nxt = S_BF_SUM;
      S_BF_SUM: state_nxt = S_BF_WA;
      S_BF_WA:  state_nxt = S_BF_WB;
      S_BF_WB: begin
        state_nxt = S_BF_RD;
        bf_nxt    = bf_r + (LOG_N-1)'(1);
        if (bf_r == (LOG_N-1)'(FRAME_SIZE / 2 - 1)) begin
          stage_nxt = stage_r + ST_W'(1);
          if (stage_r == ST_W'(LOG_N - 1)) begin
            idx_nxt   = '0;
            state_nxt = inv_r ? S_OUT_RD : S_GN_RD;
          end
        end
      end
      S_GN_RD: begin
        if (rv < idx_r) begin
          idx_nxt = idx_r + addr_t'(1);
        end else begin
          state_nxt = S_GN_MUL;
        end
      end
      S_GN_MUL: state_nxt = S_GN_WA;
      S_GN_WA, S_GN_WB: begin
        if (state_r == S_GN_WA && rv != idx_r) begin
          state_nxt = S_GN_WB;
        end else if (idx_r == addr_t'(FRAME_SIZE - 1)) begin
          state_nxt = S_BF_RD;
          stage_nxt = '0;
          bf_nxt    = '0;
          inv_nxt   = 1'b1;
        end else begin
          idx_nxt   = idx_r + addr_t'(1);
          state_nxt = S_GN_RD;
        end
      end
      S_OUT_RD: begin
        idx_nxt = idx_r + addr_t'(1);
        if (idx_r == addr_t'(FRAME_SIZE - 1)) begin
          state_nxt = S_OUT_LAST;
        end
      end
      S_OUT_LAST: begin
        state_nxt  = S_IDLE;
        played_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      stage_r     <= '0;
      bf_r        <= '0;
      idx_r       <= '0;
      inv_r       <= 1'b0;
      played_r    <= 1'b0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      stage_r     <= stage_nxt;
      bf_r        <= bf_nxt;
      idx_r       <= idx_nxt;
      inv_r       <= inv_nxt;
      played_r    <= played_nxt;
      out_valid_r <= acc_smp;
      rd_pend_r   <= (state_r == S_OUT_RD);
    end
  end

  // Payload registers: output flags, pass address, scaled bins.
  always_ff @(posedge clk) begin
    out_last_r <= (pos_r == addr_t'(FRAME_SIZE - 1));
    out_zero_r <= !played_r;
    rd_addr_r  <= idx_r;
    if (state_r == S_GN_MUL) begin
      sc_i_r.re <= scale(wq_a.re, gq_a);
      sc_i_r.im <= scale(wq_a.im, gq_a);
      sc_j_r.re <= scale(wq_b.re, gq_b);
      sc_j_r.im <= scale(wq_b.im, gq_b);
    end
  end

  // Butterfly unit.
  assign bf_ctl.tw_ld   = (state_r == S_BF_RD);
  assign bf_ctl.mul_ld  = (state_r == S_BF_MUL);
  assign bf_ctl.sum_ld  = (state_r == S_BF_SUM);
  assign bf_ctl.inverse = inv_r;

  ffe_butterfly u_bf (
    .clk   (clk),
    .ctl   (bf_ctl),
    .tw_c  (w.c),
    .tw_s  (w.s),
    .a     (wq_a),
    .b     (wq_b),
    .a_new (a_new),
    .b_new (b_new)
  );

  // Gain table.
  assign gain_wr.en   = accept && in_mode;
  assign gain_wr.addr = in_gain_index;
  assign gain_wr.val  = in_gain_value;

  ffe_gain_store u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (gain_wr),
    .rd_en     (g_rd),
    .rd_addr_a (idx_r),
    .rd_addr_b (rv),
    .q_a       (gq_a),
    .q_b       (gq_b),
    .clearing  (clearing)
  );

  // Playback frame.
  assign pb_wr.en   = rd_pend_r;
  assign pb_wr.addr = rd_addr_r;
  assign pb_wr.re   = wq_a.re;

  ffe_playback u_pb (
    .clk     (clk),
    .wr      (pb_wr),
    .rd_en   (acc_smp),
    .rd_addr (pos_r),
    .q       (pb_q)
  );

  assign out_valid      = out_valid_r;
  assign out_frame_last = out_last_r;
  assign out_sample_out = out_zero_r ? '0 : pb_q;

  `FFE_ASSERT_NXT(a_result_follows_sample, clk, rst_n, start && !busy && !in_mode, out_valid)
  `FFE_ASSERT_IMP(a_result_has_sample, clk, rst_n, out_valid, $past(start && !busy && !in_mode))
  `FFE_ASSERT_IMP(a_busy_while_working, clk, rst_n, state_r != S_IDLE, busy)
  `FFE_ASSERT_NXT(a_frame_end_starts_fft, clk, rst_n, acc_smp && pos_r == addr_t'(FRAME_SIZE - 1), state_r == S_BF_RD && !inv_r)

endmodule

[hw/rtl/ffe_butterfly.sv]
// Radix-2 butterfly datapath: twiddle, product and sum registers.
`timescale 1ns / 1ps
module ffe_butterfly (
  input  logic            clk,
  input  ffe_pkg::bf_ctl_t ctl,
  input  ffe_pkg::tw_t    tw_c,
  input  ffe_pkg::tw_t    tw_s,
  input  ffe_pkg::cplx_t  a,
  input  ffe_pkg::cplx_t  b,
  output ffe_pkg::cplx_t  a_new,
  output ffe_pkg::cplx_t  b_new
);
  import ffe_pkg::*;

  localparam int P_W = TW_W + WORD_W;
  localparam int T_W = P_W + 1 - 15;
  localparam int S_W = T_W + 1;

  tw_t wr_r, wi_r;
  logic signed [P_W-1:0] prr_r, pii_r, pri_r, pir_r;
  logic signed [T_W-1:0] tr_r, ti_r;
  logic signed [P_W:0]   tr_sum, ti_sum;
  logic signed [S_W-1:0] ar_p, ar_m, ai_p, ai_m;

  // Twiddle register; the forward transform uses the conjugate.
  always_ff @(posedge clk) begin
    if (ctl.tw_ld) begin
      wr_r <= tw_c;
      wi_r <= ctl.inverse ? tw_s : -tw_s;
    end
  end

  // Partial products of w * b.
  always_ff @(posedge clk) begin
    if (ctl.mul_ld) begin
      prr_r <= wr_r * b.re;
      pii_r <= wi_r * b.im;
      pri_r <= wr_r * b.im;
      pir_r <= wi_r * b.re;
    end
  end

  // Rounded Q15 product t.
  assign tr_sum = (P_W+1)'(prr_r) - (P_W+1)'(pii_r) + (P_W+1)'(16384);
  assign ti_sum = (P_W+1)'(pri_r) + (P_W+1)'(pir_r) + (P_W+1)'(16384);

  always_ff @(posedge clk) begin
    if (ctl.sum_ld) begin
      tr_r <= T_W'(tr_sum >>> 15);
      ti_r <= T_W'(ti_sum >>> 15);
    end
  end

  // Sum and difference; forward stages halve with rounding.
  assign ar_p = S_W'(a.re) + S_W'(tr_r);
  assign ar_m = S_W'(a.re) - S_W'(tr_r);
  assign ai_p = S_W'(a.im) + S_W'(ti_r);
  assign ai_m = S_W'(a.im) - S_W'(ti_r);

  always_comb begin
    if (ctl.inverse) begin
      a_new.re = WORD_W'(ar_p);
      a_new.im = WORD_W'(ai_p);
      b_new.re = WORD_W'(ar_m);
      b_new.im = WORD_W'(ai_m);
    end else begin
      a_new.re = WORD_W'((ar_p + S_W'(1)) >>> 1);
      a_new.im = WORD_W'((ai_p + S_W'(1)) >>> 1);
      b_new.re = WORD_W'((ar_m + S_W'(1)) >>> 1);
      b_new.im = WORD_W'((ai_m + S_W'(1)) >>> 1);
    end
  end

endmodule

[hw/rtl/ffe_gain_store.sv]
// Bin gain memory with a clearing sweep after reset.
`timescale 1ns / 1ps
module ffe_gain_store (
  input  logic              clk,
  input  logic              rst_n,
  input  ffe_pkg::gain_wr_t wr,
  input  logic              rd_en,
  input  ffe_pkg::addr_t    rd_addr_a,
  input  ffe_pkg::addr_t    rd_addr_b,
  output ffe_pkg::gain_t    q_a,
  output ffe_pkg::gain_t    q_b,
  output logic              clearing
);
  import ffe_pkg::*;

  gain_t gain_mem [0:FRAME_SIZE-1];
  logic  clr_r, clr_nxt;
  addr_t clr_addr_r, clr_addr_nxt;

  // Clearing sweep, one entry per cycle.
  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      clr_addr_nxt = clr_addr_r + addr_t'(1);
      if (clr_addr_r == addr_t'(FRAME_SIZE - 1)) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (clr_r) begin
      gain_mem[clr_addr_r] <= '0;
    end else if (wr.en) begin
      gain_mem[wr.addr] <= wr.val;
    end
    if (rd_en) begin
      q_a <= gain_mem[rd_addr_a];
      q_b <= gain_mem[rd_addr_b];
    end
  end

  assign clearing = clr_r;

endmodule

[hw/rtl/ffe_playback.sv]
// Playback frame memory with output rounding and saturation.
`timescale 1ns / 1ps
module ffe_playback (
  input  logic            clk,
  input  ffe_pkg::pb_wr_t wr,
  input  logic            rd_en,
  input  ffe_pkg::addr_t  rd_addr,
  output ffe_pkg::sample_t q
);
  import ffe_pkg::*;

  localparam int Y_W = WORD_W + 1 - GUARD;

  sample_t pb_mem [0:FRAME_SIZE-1];
  logic signed [WORD_W:0] rnd;
  logic signed [Y_W-1:0]  y;
  sample_t                sat;

  // Drop the guard bits with rounding, then clamp.
  assign rnd = (WORD_W+1)'(wr.re) + (WORD_W+1)'(1 << (GUARD - 1));
  assign y   = Y_W'(rnd >>> GUARD);

  always_comb begin
    if (y > Y_W'((1 << (SAMPLE_BITS - 1)) - 1)) begin
      sat = sample_t'((1 << (SAMPLE_BITS - 1)) - 1);
    end else if (y < -Y_W'(1 << (SAMPLE_BITS - 1))) begin
      sat = sample_t'(-(1 << (SAMPLE_BITS - 1)));
    end else begin
      sat = sample_t'(y);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      pb_mem[wr.addr] <= sat;
    end
    if (rd_en) begin
      q <= pb_mem[rd_addr];
    end
  end

endmodule

[tb/fft_frame_equalizer_core_checker.sv]
// Checker for the frame equalizer: predicts every output sample and compares it.
`timescale 1ns / 1ps
module fft_frame_equalizer_core_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic             in_mode,
  input  ffe_pkg::sample_t in_sample_in,
  input  ffe_pkg::addr_t   in_gain_index,
  input  ffe_pkg::gain_t   in_gain_value,
  input  logic             out_valid,
  input  ffe_pkg::sample_t out_sample_out,
  input  logic             out_frame_last,
  output int               fail_count,
  output int               pending,
  output int               frames_done
);
  import ffe_pkg::*;

  typedef struct {
    sample_t smp;
    logic    last;
  } eq_sample_t;

  eq_sample_t expected_samples[$];

  longint qsin_q15 [0:QUARTER];
  longint cap_buf  [0:FRAME_SIZE-1];
  longint pb_buf   [0:FRAME_SIZE-1];
  longint gain_tab [0:FRAME_SIZE-1];
  longint spec_re  [0:FRAME_SIZE-1];
  longint spec_im  [0:FRAME_SIZE-1];
  int     wr_pos;

  // Round half up by an arithmetic right shift.
  function automatic longint rnd_shift(input longint v, input int s);
    if (s == 0) begin
      return v;
    end
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // Truncated Taylor sine in Q30, rounded to Q15.
  function automatic longint taylor_sin(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return (sum + 16384) >>> 15;
  endfunction

  // In-place radix-2 transform; the forward direction halves every stage.
  task automatic run_fft(input bit inverse);
    int     j;
    int     half;
    int     stp;
    int     k;
    longint c;
    longint s;
    longint wi;
    longint tr;
    longint ti;
    longint tmp;
    int     ia;
    int     ib;
    for (int i = 0; i < FRAME_SIZE; i++) begin
      j = 0;
      for (int b = 0; b < LOG_N; b++) begin
        if (i[b]) begin
          j |= 1 << (LOG_N - 1 - b);
        end
      end
      if (j > i) begin
        tmp = spec_re[i]; spec_re[i] = spec_re[j]; spec_re[j] = tmp;
        tmp = spec_im[i]; spec_im[i] = spec_im[j]; spec_im[j] = tmp;
      end
    end
    for (int len = 2; len <= FRAME_SIZE; len <<= 1) begin
      half = len / 2;
      stp  = FRAME_SIZE / len;
      for (int st = 0; st < FRAME_SIZE; st += len) begin
        for (int m = 0; m < half; m++) begin
          k = m * stp;
          if (k <= QUARTER) begin
            c = qsin_q15[QUARTER - k];
            s = qsin_q15[k];
          end else begin
            c = -qsin_q15[k - QUARTER];
            s = qsin_q15[FRAME_SIZE / 2 - k];
          end
          wi = inverse ? s : -s;
          ia = st + m;
          ib = st + m + half;
          tr = rnd_shift(c * spec_re[ib] - wi * spec_im[ib], 15);
          ti = rnd_shift(c * spec_im[ib] + wi * spec_re[ib], 15);
          if (inverse) begin
            spec_re[ib] = spec_re[ia] - tr;
            spec_im[ib] = spec_im[ia] - ti;
            spec_re[ia] = spec_re[ia] + tr;
            spec_im[ia] = spec_im[ia] + ti;
          end else begin
            spec_re[ib] = rnd_shift(spec_re[ia] - tr, 1);
            spec_im[ib] = rnd_shift(spec_im[ia] - ti, 1);
            spec_re[ia] = rnd_shift(spec_re[ia] + tr, 1);
            spec_im[ia] = rnd_shift(spec_im[ia] + ti, 1);
          end
        end
      end
    end
  endtask

  // Equalize a full capture frame into the playback frame.
  task automatic equalize_frame();
    longint y;
    for (int i = 0; i < FRAME_SIZE; i++) begin
      spec_re[i] = cap_buf[i] <<< GUARD;
      spec_im[i] = 0;
    end
    run_fft(1'b0);
    for (int i = 0; i < FRAME_SIZE; i++) begin
      spec_re[i] = rnd_shift(spec_re[i] * gain_tab[i], GAIN_FRAC);
      spec_im[i] = rnd_shift(spec_im[i] * gain_tab[i], GAIN_FRAC);
    end
    run_fft(1'b1);
    for (int i = 0; i < FRAME_SIZE; i++) begin
      y = rnd_shift(spec_re[i], GUARD);
      if (y > 32767) begin
        y = 32767;
      end
      if (y < -32768) begin
        y = -32768;
      end
      pb_buf[i] = y;
    end
  endtask

  // Twiddle table, fixed for the whole run.
  initial begin
    for (int k = 0; k <= QUARTER; k++) begin
      qsin_q15[k] = taylor_sin((PI_Q30 * 64'd2 * 64'(k)) / FRAME_SIZE);
    end
  end

  assign pending = expected_samples.size();

  // Compare outputs, then predict the transaction accepted at this edge.
  always @(posedge clk) begin
    eq_sample_t e;
    eq_sample_t got;
    if (!rst_n) begin
      for (int i = 0; i < FRAME_SIZE; i++) begin
        pb_buf[i]   = 0;
        gain_tab[i] = 0;
        cap_buf[i]  = 0;
      end
      wr_pos = 0;
      expected_samples.delete();
      fail_count  <= 0;
      frames_done <= 0;
    end else begin
      if (out_valid) begin
        got.smp  = out_sample_out;
        got.last = out_frame_last;
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected output: actual sample %0d last %0b",
                   $time, got.smp, got.last);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_samples.pop_front();
          if (e.smp !== got.smp || e.last !== got.last) begin
            $display("%0t: mismatch: expected sample %0d last %0b, actual sample %0d last %0b",
                     $time, e.smp, e.last, got.smp, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        if (in_mode) begin
          if (int'(in_gain_index) < FRAME_SIZE) begin
            gain_tab[in_gain_index] = longint'(in_gain_value);
          end
        end else begin
          e.smp  = sample_t'(pb_buf[wr_pos]);
          e.last = (wr_pos == FRAME_SIZE - 1);
          expected_samples.push_back(e);
          cap_buf[wr_pos] = longint'(in_sample_in);
          wr_pos++;
          if (wr_pos >= FRAME_SIZE) begin
            equalize_frame();
            wr_pos = 0;
            frames_done <= frames_done + 1;
          end
        end
      end
    end
  end

endmodule

[tb/fft_frame_equalizer_core_tb.sv]
// Testbench top for the frame equalizer: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module fft_frame_equalizer_core_tb;
  import ffe_pkg::*;

  localparam int CYCLE_LIMIT = 1200000;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    start = 1'b0;
  logic    in_mode = 1'b0;
  sample_t in_sample_in = '0;
  addr_t   in_gain_index = '0;
  gain_t   in_gain_value = '0;
  logic    busy;
  logic    out_valid;
  sample_t out_sample_out;
  logic    out_frame_last;
  int      fail_count;
  int      pending;
  int      frames_done;
  int      cycle_cnt = 0;
  int      n_samples = 0;
  int      n_gains = 0;

  always #1 clk = ~clk;

  fft_frame_equalizer_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_sample_in  (in_sample_in),
    .in_gain_index (in_gain_index),
    .in_gain_value (in_gain_value),
    .out_valid     (out_valid),
    .out_sample_out(out_sample_out),
    .out_frame_last(out_frame_last)
  );

  fft_frame_equalizer_core_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_sample_in  (in_sample_in),
    .in_gain_index (in_gain_index),
    .in_gain_value (in_gain_value),
    .out_valid     (out_valid),
    .out_sample_out(out_sample_out),
    .out_frame_last(out_frame_last),
    .fail_count    (fail_count),
    .pending       (pending),
    .frames_done   (frames_done)
  );

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("fft_frame_equalizer_core regression: fail");
      $finish;
    end
  end

  // Random idle gap: mostly none, sometimes short, rarely long.
  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      n = 0;
    end else if (r < 95) begin
      n = $urandom_range(1, 3);
    end else begin
      n = $urandom_range(10, 40);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Present one transaction and hold it until the block takes it.
  task automatic send(input logic mode, input sample_t smp, input addr_t idx, input gain_t g);
    start         <= 1'b1;
    in_mode       <= mode;
    in_sample_in  <= smp;
    in_gain_index <= idx;
    in_gain_value <= g;
    do begin
      @(posedge clk);
    end while (busy);
    if (mode) begin
      n_gains++;
    end else begin
      n_samples++;
    end
  endtask

  task automatic send_sample(input sample_t smp);
    send(1'b0, smp, addr_t'($urandom), gain_t'($urandom));
  endtask

  task automatic send_gain(input addr_t idx, input gain_t g);
    send(1'b1, sample_t'($urandom), idx, g);
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 3))
      0: return sample_t'($urandom);
      1: return $urandom_range(0, 1) ? sample_t'(16'sh7fff) : sample_t'(16'sh8000);
      2: return sample_t'(int'($urandom_range(0, 511)) - 256);
      default: return sample_t'(int'($urandom_range(0, 16383)) - 8192);
    endcase
  endfunction

  function automatic gain_t rand_gain();
    case ($urandom_range(0, 9))
      0: return gain_t'(0);
      1: return gain_t'(4095);
      2, 3: return gain_t'($urandom);
      default: return gain_t'($urandom_range(200, 320));
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme gains at the edge bins, unity at bin 1, then samples with one more gain write.
    send_gain(addr_t'(0), gain_t'(4095));
    send_gain(addr_t'(FRAME_SIZE - 1), gain_t'(0));
    send_gain(addr_t'(1), gain_t'(256));
    send_sample(sample_t'(16'sh7fff));
    send_sample(sample_t'(16'sh8000));
    send_sample(sample_t'(0));
    send_sample(sample_t'(-1));
    send_sample(sample_t'(1));
    send_gain(addr_t'(2), gain_t'(4095));
    send_sample(sample_t'(16'sh5555));
    send_sample(sample_t'(16'shaaaa));

    // Scatter gain writes over random bins between samples of the first frame.
    for (int i = 0; i < 40; i++) begin
      send_gain(addr_t'($urandom_range(3, FRAME_SIZE - 2)), rand_gain());
      send_sample(rand_sample());
      idle_gap();
    end

    // Complete the first frame; its playback is all zeros.
    while (n_samples < FRAME_SIZE) begin
      send_sample(rand_sample());
      idle_gap();
      if (n_samples == 500) begin
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end

    // Start of the second frame, with scattered gain updates.
    while (n_samples < FRAME_SIZE + 60) begin
      if ($urandom_range(0, 9) == 0) begin
        send_gain(addr_t'($urandom), rand_gain());
      end else begin
        send_sample(rand_sample());
      end
      idle_gap();
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d sample and %0d gain transactions, %0d frames equalized.",
             n_samples, n_gains, frames_done);
    if (fail_count == 0) begin
      $display("fft_frame_equalizer_core regression: pass");
    end else begin
      $display("fft_frame_equalizer_core regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/ffe_pkg.sv
hw/rtl/ffe_butterfly.sv
hw/rtl/ffe_gain_store.sv
hw/rtl/ffe_playback.sv
hw/rtl/fft_frame_equalizer_core.sv
tb/fft_frame_equalizer_core_checker.sv
tb/fft_frame_equalizer_core_tb.sv
